FILE: rtl/tcst_pkg.sv
// Shared types and constants for the touch contact slot tracker.
package tcst_pkg;

  localparam int SLOT_W  = 4;
  localparam int STATE_W = 2;
  localparam int HIGH_W  = 8;
  localparam int LOW_W   = 4;
  localparam int POS_W   = HIGH_W + LOW_W;
  localparam int RANK_W  = 4;

  localparam logic [SLOT_W-1:0] MAXF_RESET = 4'd10;
  localparam logic [STATE_W-1:0] ST_ABSENT = 2'd0;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_index;
    logic [STATE_W-1:0] slot_state;
    logic [HIGH_W-1:0]  x_high;
    logic [LOW_W-1:0]   x_low;
    logic [HIGH_W-1:0]  y_high;
    logic [LOW_W-1:0]   y_low;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  out_slot;
    logic [STATE_W-1:0] cached_state;
    logic [POS_W-1:0]   x_position;
    logic [POS_W-1:0]   y_position;
    logic               slot_active;
    logic               slot_lifted;
    logic [RANK_W-1:0]  contact_count;
    logic [RANK_W-1:0]  arrival_rank;
  } out_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
  } cache_entry_t;

endpackage

FILE: rtl/touch_contact_slot_tracker_top.sv
// Touch contact slot tracker: per-slot contact cache and arrival-order list.
//
// One item per finger slot comes in, a report starting at slot 0, and one
// result item goes out per input item with the slot's cached state, x/y,
// active and lifted flags, the contact count and the slot's arrival rank
// (MAX_SLOTS when the slot is not listed). A single compare unit walks the
// arrival list one entry per cycle under a small sequencer, so the block
// takes one item at a time and in_ready is low while it works. An item on a
// slot other than 0 passes through accept, update and a rank scan of the list
// entries until the slot is found or the list ends. An item on slot 0
// also sweeps the lifted slots: each slot below the active limit is checked,
// and for each lifted slot the list is scanned until the slot is found and
// removed (the removal shifts the tail of the list up by one entry). The result
// sits in an output register, so the next item is accepted while it waits;
// the sequencer stalls only if a new result is ready before the last one was
// taken. The max_fingers register is written through cfg_valid/cfg_data and
// is always ready; write it only while the block is idle. Resets to 10.
module touch_contact_slot_tracker_top #(
  parameter int MAX_SLOTS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  tcst_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tcst_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tcst_pkg::SLOT_W-1:0]            cfg_data
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [tcst_pkg::SLOT_W-1:0]   LAST_SLOT = tcst_pkg::SLOT_W'(MAX_SLOTS - 1);
  localparam logic [tcst_pkg::SLOT_W:0]     SLOT_LIM  = (tcst_pkg::SLOT_W + 1)'(MAX_SLOTS);
  localparam logic [CNT_W-1:0]              CNT_FULL  = CNT_W'(MAX_SLOTS);
  localparam logic [tcst_pkg::RANK_W-1:0]   NO_RANK   = tcst_pkg::RANK_W'(MAX_SLOTS);

  // One-hot sequencer: idle, sweep select, sweep scan, update, rank scan.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SEL  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_RANK = 5'b10000
  } fsm_t;

  fsm_t                              state_r, state_nxt;
  tcst_pkg::in_item_t                item_r, item_nxt;
  logic                              range_r, range_nxt;
  logic [tcst_pkg::SLOT_W-1:0]       i_r, i_nxt;
  logic [CNT_W-1:0]                  j_r, j_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [MAX_SLOTS-1:0]              valid_r, valid_nxt;
  logic [MAX_SLOTS-1:0]              dirty_r, dirty_nxt;
  logic [tcst_pkg::SLOT_W-1:0]       order_r   [MAX_SLOTS];
  logic [tcst_pkg::SLOT_W-1:0]       order_nxt [MAX_SLOTS];
  tcst_pkg::cache_entry_t            cache_r   [MAX_SLOTS];
  tcst_pkg::cache_entry_t            cache_nxt [MAX_SLOTS];
  logic [tcst_pkg::SLOT_W-1:0]       maxf_r, maxf_nxt;
  logic                              out_valid_r, out_valid_nxt;
  tcst_pkg::out_item_t               out_r, out_nxt;

  logic [tcst_pkg::SLOT_W-1:0]       maxf_m1;
  logic [tcst_pkg::SLOT_W-1:0]       lim_last;
  logic                              in_slot_ok;
  logic                              slot_lt_max;
  logic [IDX_W-1:0]                  i_idx;
  logic [IDX_W-1:0]                  j_idx;
  logic [IDX_W-1:0]                  s_idx;
  logic [tcst_pkg::SLOT_W-1:0]       list_rd;
  logic [tcst_pkg::SLOT_W-1:0]       target;
  logic                              hit;
  logic                              scan_end;
  logic                              last_sweep;

  assign maxf_m1     = maxf_r - 4'd1;
  assign lim_last    = (maxf_m1 < LAST_SLOT) ? maxf_m1 : LAST_SLOT;
  assign in_slot_ok  = (in_data.slot_index < maxf_r) && ({1'b0, in_data.slot_index} < SLOT_LIM);
  assign slot_lt_max = {1'b0, item_r.slot_index} < SLOT_LIM;
  assign i_idx       = i_r[IDX_W-1:0];
  assign j_idx       = j_r[IDX_W-1:0];
  assign s_idx       = item_r.slot_index[IDX_W-1:0];
  assign last_sweep  = (i_r == lim_last);

  // Shared compare unit: one list entry per cycle against the sweep slot or
  // the item's own slot.
  assign list_rd  = order_r[j_idx];
  assign target   = (state_r == ST_SCAN) ? i_r : item_r.slot_index;
  assign hit      = (list_rd == target);
  assign scan_end = (j_r == cnt_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    range_nxt     = range_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    order_nxt     = order_r;
    cache_nxt     = cache_r;
    maxf_nxt      = maxf_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (cfg_valid) begin
      maxf_nxt = cfg_data;
    end
    // Drop the held result once it is taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          range_nxt = in_slot_ok;
          i_nxt     = '0;
          if (in_slot_ok && (in_data.slot_index == '0)) begin
            state_nxt = ST_SEL;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end

      ST_SEL: begin
        if (dirty_r[i_idx]) begin
          j_nxt     = '0;
          state_nxt = ST_SCAN;
        end else if (last_sweep) begin
          state_nxt = ST_UPD;
        end else begin
          i_nxt = i_r + 4'd1;
        end
      end

      ST_SCAN: begin
        if (scan_end || hit) begin
          if (!scan_end) begin
            // Remove the entry: every later entry moves up by one.
            for (int k = 0; k < MAX_SLOTS - 1; k++) begin
              if (CNT_W'(k) >= j_r) begin
                order_nxt[k] = order_r[k+1];
              end
            end
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          dirty_nxt[i_idx] = 1'b0;
          if (last_sweep) begin
            state_nxt = ST_UPD;
          end else begin
            i_nxt     = i_r + 4'd1;
            state_nxt = ST_SEL;
          end
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end

      ST_UPD: begin
        j_nxt     = '0;
        state_nxt = ST_RANK;
        if (range_r) begin
          if ((item_r.slot_state != tcst_pkg::ST_ABSENT) && !valid_r[s_idx]) begin
            valid_nxt[s_idx] = 1'b1;
            if (cnt_r != CNT_FULL) begin
              order_nxt[cnt_r[IDX_W-1:0]] = item_r.slot_index;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
          if (valid_r[s_idx] || (item_r.slot_state != tcst_pkg::ST_ABSENT)) begin
            cache_nxt[s_idx].state = item_r.slot_state;
            cache_nxt[s_idx].x     = {item_r.x_high, item_r.x_low};
            cache_nxt[s_idx].y     = {item_r.y_high, item_r.y_low};
            if (item_r.slot_state == tcst_pkg::ST_ABSENT) begin
              dirty_nxt[s_idx] = 1'b1;
              valid_nxt[s_idx] = 1'b0;
            end
          end
        end
      end

      ST_RANK: begin
        if (scan_end || hit) begin
          // Hold here while the output register is still full.
          if (!out_valid_r || out_ready) begin
            out_nxt.out_slot      = item_r.slot_index;
            out_nxt.contact_count = tcst_pkg::RANK_W'(cnt_r);
            out_nxt.arrival_rank  = scan_end ? NO_RANK : tcst_pkg::RANK_W'(j_r);
            if (slot_lt_max) begin
              out_nxt.cached_state = cache_r[s_idx].state;
              out_nxt.x_position   = cache_r[s_idx].x;
              out_nxt.y_position   = cache_r[s_idx].y;
              out_nxt.slot_active  = valid_r[s_idx];
              out_nxt.slot_lifted  = dirty_r[s_idx];
            end else begin
              out_nxt.cached_state = '0;
              out_nxt.x_position   = '0;
              out_nxt.y_position   = '0;
              out_nxt.slot_active  = 1'b0;
              out_nxt.slot_lifted  = 1'b0;
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      dirty_r     <= '0;
      maxf_r      <= tcst_pkg::MAXF_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        cache_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      maxf_r      <= maxf_nxt;
      out_valid_r <= out_valid_nxt;
      cache_r     <= cache_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    range_r <= range_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    order_r <= order_nxt;
    out_r   <= out_nxt;
  end

  // The list never holds more entries than there are slots.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("contact count beyond slot count");

  // The lifted-slot sweep runs only for a slot-0 item.
  a_sweep_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL || state_r == ST_SCAN) |-> (item_r.slot_index == '0))
    else $error("sweep running for a slot other than 0");

  // A list scan during the sweep is only for a lifted slot.
  a_scan_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> dirty_r[i_idx])
    else $error("sweep scan for a slot that is not lifted");

  // The count moves only in the removal scan or the update step.
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_SEL || state_r == ST_RANK) |=> $stable(cnt_r))
    else $error("contact count changed outside update or sweep");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the touch contact slot tracker.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_SLOTS = 10;
  // Slowest item: a slot-0 sweep over ten lifted slots, each scanning up to ten
  // list entries, plus the rank scan, stacked behind a long output stall and a
  // sender gap. The limit leaves room for that several times over.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to let pass once nothing is expected any more.
  localparam int SETTLE_CYCLES = 200;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PATTERN,
    RDY_SPARSE
  } ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tcst_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tcst_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tcst_pkg::SLOT_W-1:0] cfg_data = '0;

  touch_contact_slot_tracker_top #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker shadow: per-slot flags, cache, arrival list and the finger limit.
  // ---------------------------------------------------------------------------
  logic [MAX_SLOTS-1:0]          track_active = '0;
  logic [MAX_SLOTS-1:0]          track_lifted = '0;
  logic [tcst_pkg::SLOT_W-1:0]   track_order [MAX_SLOTS];
  int                            track_count = 0;
  tcst_pkg::cache_entry_t        track_cache [MAX_SLOTS];
  logic [tcst_pkg::SLOT_W-1:0]   track_max_fingers = tcst_pkg::MAXF_RESET;

  tcst_pkg::out_item_t expected_slot_views [$];
  int        failures = 0;
  int        burst_left = 0;
  logic      finger_down [16];

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      track_order[i] = '0;
      track_cache[i] = '0;
    end
    for (int i = 0; i < 16; i++) finger_down[i] = 1'b0;
  end

  function automatic int active_limit();
    return (int'(track_max_fingers) < MAX_SLOTS) ? int'(track_max_fingers) : MAX_SLOTS;
  endfunction

  // First position of a slot in the arrival list, MAX_SLOTS when not listed.
  function automatic int list_position(input int slot);
    for (int j = 0; j < track_count && j < MAX_SLOTS; j++) begin
      if (track_order[j] == slot[tcst_pkg::SLOT_W-1:0]) return j;
    end
    return MAX_SLOTS;
  endfunction

  // Drop every lifted slot below the limit from the arrival list.
  function automatic void remove_lifted_slots(input int limit);
    int j;
    for (int i = 0; i < limit; i++) begin
      if (track_lifted[i]) begin
        j = list_position(i);
        if (j < MAX_SLOTS && track_count > 0) begin
          while (j + 1 < track_count && j + 1 < MAX_SLOTS) begin
            track_order[j] = track_order[j + 1];
            j++;
          end
          track_count--;
        end
        track_lifted[i] = 1'b0;
      end
    end
  endfunction

  // Apply one slot item to the shadow and return the slot view it produces.
  function automatic tcst_pkg::out_item_t update_slot_tracker(input tcst_pkg::in_item_t it);
    tcst_pkg::out_item_t view;
    int slot;
    int limit;
    slot  = int'(it.slot_index);
    limit = active_limit();
    if (slot < limit) begin
      if (slot == 0) remove_lifted_slots(limit);
      if (it.slot_state != tcst_pkg::ST_ABSENT && !track_active[slot]) begin
        track_active[slot] = 1'b1;
        if (track_count < MAX_SLOTS) begin
          track_order[track_count] = it.slot_index;
          track_count++;
        end
      end
      if (track_active[slot]) begin
        track_cache[slot].state = it.slot_state;
        track_cache[slot].x     = {it.x_high, it.x_low};
        track_cache[slot].y     = {it.y_high, it.y_low};
        if (it.slot_state == tcst_pkg::ST_ABSENT) begin
          track_lifted[slot] = 1'b1;
          track_active[slot] = 1'b0;
        end
      end
    end
    view = '0;
    view.out_slot = it.slot_index;
    if (slot < MAX_SLOTS) begin
      view.cached_state = track_cache[slot].state;
      view.x_position   = track_cache[slot].x;
      view.y_position   = track_cache[slot].y;
      view.slot_active  = track_active[slot];
      view.slot_lifted  = track_lifted[slot];
      view.arrival_rank = tcst_pkg::RANK_W'(list_position(slot));
    end else begin
      view.arrival_rank = tcst_pkg::RANK_W'(MAX_SLOTS);
    end
    view.contact_count = tcst_pkg::RANK_W'(track_count);
    return view;
  endfunction

  function automatic string describe_view(input tcst_pkg::out_item_t v);
    return $sformatf("slot %0d state %0d x %0d y %0d active %0b lifted %0b count %0d rank %0d",
                     v.out_slot, v.cached_state, v.x_position, v.y_position,
                     v.slot_active, v.slot_lifted, v.contact_count, v.arrival_rank);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tcst_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_slot_views.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result: %s", describe_view(out_data));
      end else begin
        want = expected_slot_views.pop_front();
        if (out_data !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch, expected: %s", describe_view(want));
            $display("          actual:   %s", describe_view(out_data));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between no stall, random stall, a rotating pattern and
  // heavy stall, each held for a random stretch of cycles.
  // ---------------------------------------------------------------------------
  ready_mode_t ready_mode = RDY_ALWAYS;
  int          ready_mode_left = 0;
  logic [15:0] ready_pattern = 16'h1;

  always @(posedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      <= ready_mode_t'($urandom_range(0, 3));
      ready_mode_left <= $urandom_range(50, 300);
      ready_pattern   <= 16'($urandom) | 16'h1;
      out_ready       <= 1'b1;
    end else begin
      ready_mode_left <= ready_mode_left - 1;
      case (ready_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        RDY_PATTERN: begin
          out_ready     <= ready_pattern[0];
          ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves an item for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared sender tasks.
  // ---------------------------------------------------------------------------
  function automatic tcst_pkg::in_item_t make_item(input int slot, input int st,
                                                   input int xh, input int xl,
                                                   input int yh, input int yl);
    tcst_pkg::in_item_t it;
    it.slot_index = tcst_pkg::SLOT_W'(slot);
    it.slot_state = tcst_pkg::STATE_W'(st);
    it.x_high     = tcst_pkg::HIGH_W'(xh);
    it.x_low      = tcst_pkg::LOW_W'(xl);
    it.y_high     = tcst_pkg::HIGH_W'(yh);
    it.y_low      = tcst_pkg::LOW_W'(yl);
    return it;
  endfunction

  // Send one item in the current burst; open a new burst after a random gap.
  // Valid stays high on return so back-to-back items need no second drive.
  task automatic send_item(input tcst_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_slot_views.push_back(update_slot_tracker(it));
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_slot_views.size() != 0) @(posedge clk);
  endtask

  // Write the finger limit with the block idle.
  task automatic write_max_fingers(input logic [tcst_pkg::SLOT_W-1:0] value);
    hold_until_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    track_max_fingers = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic tcst_pkg::in_item_t random_item(input int slot, input int st);
    return make_item(slot, st, $urandom_range(0, 255), $urandom_range(0, 15),
                     $urandom_range(0, 255), $urandom_range(0, 15));
  endfunction

  // One report with random content: mostly slot 0 up to the limit in order,
  // with fingers landing and lifting; now and then a short or oversized
  // report, a skipped slot or a stray slot number. Return how many items
  // fell inside the limit.
  task automatic send_random_report(output int counted);
    int limit;
    int span;
    int st;
    int stray;
    limit   = active_limit();
    counted = 0;
    span    = limit;
    if (span == 0 || $urandom_range(0, 9) == 0) span = $urandom_range(1, 15);
    for (int s = 0; s < span; s++) begin
      if ($urandom_range(0, 19) == 0) begin
        stray = $urandom_range(0, 15);
        send_item(random_item(stray, $urandom_range(0, 3)));
        if (stray < limit) counted++;
      end else if ($urandom_range(0, 19) != 0) begin
        if ($urandom_range(0, 4) == 0) finger_down[s] = !finger_down[s];
        st = finger_down[s] ? $urandom_range(1, 3) : 0;
        send_item(random_item(s, st));
        if (s < limit) counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test tasks.
  // ---------------------------------------------------------------------------

  // Build an arrival list with repeated entries, fill it, and sweep it.
  task automatic test_directed_cases();
    send_item(make_item(0, 0, 255, 15, 255, 15));   // absent on an idle slot
    send_item(make_item(0, 3, 255, 15, 255, 15));   // first contact, top coords
    send_item(make_item(1, 1, 0, 0, 0, 0));
    send_item(make_item(1, 0, 0, 0, 0, 0));         // lift
    send_item(make_item(1, 2, 1, 2, 3, 4));         // lands again: listed twice
    send_item(make_item(2, 1, 170, 5, 85, 10));
    send_item(make_item(2, 0, 85, 10, 170, 5));
    send_item(make_item(2, 3, 128, 8, 127, 7));
    for (int s = 3; s <= 7; s++) send_item(make_item(s, 1 + s % 3, s, s, 255 - s, 15 - s));
    send_item(make_item(8, 2, 200, 1, 100, 2));     // list full: active, no rank
    send_item(make_item(9, 3, 165, 10, 90, 5));
    send_item(make_item(10, 3, 255, 15, 255, 15));  // past the slot store
    send_item(make_item(15, 3, 255, 15, 255, 15));
    send_item(make_item(8, 0, 0, 0, 0, 0));         // lifted, never listed
    send_item(make_item(2, 0, 0, 0, 0, 0));         // lifted, listed twice
    send_item(make_item(0, 1, 18, 3, 52, 1));       // sweep
    send_item(make_item(1, 1, 7, 7, 7, 7));
    send_item(make_item(2, 2, 9, 9, 9, 9));
  endtask

  // Limits of zero, one and oversized.
  task automatic test_limit_extremes();
    int counted;
    logic [tcst_pkg::SLOT_W-1:0] limits [3];
    limits = '{4'd0, 4'd1, 4'd15};
    foreach (limits[i]) begin
      write_max_fingers(limits[i]);
      send_item(make_item(0, 2, 12, 3, 45, 6));
      send_item(make_item(15, 1, 255, 15, 255, 15));
      repeat (3) send_random_report(counted);
    end
  endtask

  // Random reports over several limits, pausing once until fully drained.
  task automatic test_random_reports();
    int counted;
    int done;
    logic [tcst_pkg::SLOT_W-1:0] settings [5];
    int targets [5];
    settings = '{4'd10, 4'd6, 4'd15, 4'd2, 4'd10};
    targets  = '{400, 220, 250, 100, 200};
    settings[1] = tcst_pkg::SLOT_W'($urandom_range(3, 9));
    foreach (settings[p]) begin
      write_max_fingers(settings[p]);
      done = 0;
      while (done < targets[p]) begin
        send_random_report(counted);
        done += counted;
        if (p == 2 && done >= targets[p] / 2 && done - counted < targets[p] / 2)
          hold_until_drained();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_limit_extremes();
    test_random_reports();

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures += expected_slot_views.size();
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
